// File: rtl/rc_stick_command_and_arming_macros.svh
// Assertion macros used by the checker of the stick command block.
`ifndef RC_STICK_COMMAND_AND_ARMING_MACROS_SVH
`define RC_STICK_COMMAND_AND_ARMING_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RCSCA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define RCSCA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define RCSCA_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rcsca_pkg.sv
package rcsca_pkg;

    localparam int PULSE_W = 12;
    localparam int CMD_W   = 11;
    localparam int HOLD_W  = 8;
    localparam int FLAG_W  = 8;
    localparam int NUM_CH  = 4;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;
    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;

    localparam logic [PULSE_W-1:0] PULSE_VALID_MIN = 12'd900;
    localparam logic [PULSE_W-1:0] PULSE_VALID_MAX = 12'd2000;
    localparam logic [HOLD_W-1:0]  HOLD_SATURATE   = 8'd250;

    localparam logic [PULSE_W-1:0] CENTER_RESET    = 12'd1500;
    localparam logic [PULSE_W-1:0] LOW_THR_RESET   = 12'd1100;
    localparam logic [PULSE_W-1:0] HIGH_THR_RESET  = 12'd1900;
    localparam logic [HOLD_W-1:0]  HOLD_RESET      = 8'd100;

    localparam logic [FLAG_W-1:0] FLAG_YAW_LOW  = 8'h10;
    localparam logic [FLAG_W-1:0] FLAG_YAW_HIGH = 8'h20;
    localparam logic [FLAG_W-1:0] FLAG_THR_LOW  = 8'h40;

    typedef enum logic [1:0] {
        REG_CENTER   = 2'd0,
        REG_LOW_THR  = 2'd1,
        REG_HIGH_THR = 2'd2,
        REG_HOLD     = 2'd3
    } cfg_reg_t;

endpackage

// File: rtl/rc_stick_command_and_arming.sv
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------------
// s_       | s_tvalid / s_tready           | s_tdata: roll, pitch, yaw, throttle pulse
// m_       | m_tvalid / m_tready           | m_tdata: commands and armed flag
// APB      | psel, penable, pwrite, pready | paddr, pwdata, prdata (four registers)
//
// Each frame is held in the input register and then sits in the result register,
// from which its result is offered on m_. One frame is accepted per cycle while
// results are taken on m_; the stick flags, hold counter and armed state
// are updated as a frame moves from the input register to the result register.
// A stall on m_ holds both registers; s_tready drops only when both are full.
// aresetn clears the flags, counter, armed state and valid bits and loads the
// register defaults.
module rc_stick_command_and_arming
    import rcsca_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // Fields from bit 0: roll_pulse[11:0], pitch_pulse[23:12], yaw_pulse[35:24],
    // throttle_pulse[47:36].
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // Fields from bit 0: roll_command[10:0], pitch_command[21:11], yaw_command[32:22],
    // throttle_command[44:33], armed_flag[45], zero fill [47:46].
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    logic [PULSE_W-1:0] center_reg;
    logic [PULSE_W-1:0] low_thr_reg;
    logic [PULSE_W-1:0] high_thr_reg;
    logic [HOLD_W-1:0]  hold_reg;

    logic               in_valid_reg;
    logic [PULSE_W-1:0] pulse_reg [NUM_CH];
    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [FLAG_W-1:0]  flags_reg;
    logic [HOLD_W-1:0]  count_reg;
    logic               armed_reg;

    logic [FLAG_W-1:0]  flags_next;
    logic [HOLD_W-1:0]  count_next;
    logic               armed_next;
    logic [M_DATA_W-1:0] out_data_next;

    logic               advance;
    logic               cfg_write;
    logic               chain_ok;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;

    // Difference from centre divided by four, rounded toward zero.
    function automatic logic signed [CMD_W-1:0] scale_cmd(
        input logic [PULSE_W-1:0] pulse,
        input logic [PULSE_W-1:0] center
    );
        logic signed [PULSE_W:0] diff;
        logic signed [PULSE_W:0] biased;
        diff   = $signed({1'b0, pulse}) - $signed({1'b0, center});
        biased = diff + (diff[PULSE_W] ? (PULSE_W+1)'(3) : (PULSE_W+1)'(0));
        return biased[PULSE_W:2];
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_reg_t'(paddr[3:2]))
            REG_CENTER:   prdata = {(APB_W-PULSE_W)'(0), center_reg};
            REG_LOW_THR:  prdata = {(APB_W-PULSE_W)'(0), low_thr_reg};
            REG_HIGH_THR: prdata = {(APB_W-PULSE_W)'(0), high_thr_reg};
            REG_HOLD:     prdata = {(APB_W-HOLD_W)'(0), hold_reg};
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        roll_cmd  = scale_cmd(pulse_reg[0], center_reg);
        pitch_cmd = scale_cmd(pulse_reg[1], center_reg);
        yaw_cmd   = -scale_cmd(pulse_reg[2], center_reg);

        // The first pulse outside the valid window stops flagging for this frame.
        chain_ok   = 1'b1;
        flags_next = flags_reg;
        for (int i = 0; i < NUM_CH; i++) begin
            if (pulse_reg[i] < PULSE_VALID_MIN || pulse_reg[i] > PULSE_VALID_MAX) begin
                chain_ok = 1'b0;
            end
            if (chain_ok) begin
                if (pulse_reg[i] < low_thr_reg) begin
                    flags_next[2*i] = 1'b1;
                end else if (pulse_reg[i] > high_thr_reg) begin
                    flags_next[2*i+1] = 1'b1;
                end
            end
        end

        if (flags_next != '0) begin
            count_next = (count_reg < HOLD_SATURATE) ? count_reg + 1'b1 : count_reg;
        end else begin
            count_next = '0;
        end

        armed_next = armed_reg;
        if (count_next == hold_reg) begin
            if (armed_reg) begin
                if ((flags_next & FLAG_YAW_LOW) != '0 && (flags_next & FLAG_THR_LOW) != '0) begin
                    armed_next = 1'b0;
                end
            end else begin
                if ((flags_next & FLAG_YAW_HIGH) != '0 && (flags_next & FLAG_THR_LOW) != '0) begin
                    armed_next = 1'b1;
                end
            end
            flags_next = '0;
            count_next = '0;
        end

        out_data_next = {2'b00, armed_next, pulse_reg[3], yaw_cmd, pitch_cmd, roll_cmd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= CENTER_RESET;
            low_thr_reg   <= LOW_THR_RESET;
            high_thr_reg  <= HIGH_THR_RESET;
            hold_reg      <= HOLD_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_reg_t'(paddr[3:2]))
                    REG_CENTER:   center_reg   <= pwdata[PULSE_W-1:0];
                    REG_LOW_THR:  low_thr_reg  <= pwdata[PULSE_W-1:0];
                    REG_HIGH_THR: high_thr_reg <= pwdata[PULSE_W-1:0];
                    REG_HOLD:     hold_reg     <= pwdata[HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    flags_reg <= flags_next;
                    count_reg <= count_next;
                    armed_reg <= armed_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            for (int i = 0; i < NUM_CH; i++) begin
                pulse_reg[i] <= s_tdata[i*PULSE_W +: PULSE_W];
            end
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: rtl/rcsca_checker.sv
`include "rc_stick_command_and_arming_macros.svh"

module rcsca_checker
    import rcsca_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A result that is not taken must stay in place.
    `RCSCA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // The input side only stalls when a finished result is waiting.
    `RCSCA_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without a waiting result")

    // No result may appear right after reset.
    `RCSCA_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // An accepted frame with the result side ready passes the input register and then reaches the output.
    `RCSCA_ASSERT_NXT(a_latency, aclk, aresetn, s_tvalid && s_tready && m_tready && !m_tvalid, ##1 m_tvalid, "frame did not reach the output in time")

    // The fill bits above the armed flag stay zero.
    `RCSCA_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[47:46] == 2'b00, "fill bits of result are not zero")

endmodule

bind rc_stick_command_and_arming rcsca_checker u_rcsca_checker (.*);

// File: verif/rc_stick_command_and_arming_tb.sv
module rc_stick_command_and_arming_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcsca_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PULSE_MIN_I = int'(PULSE_VALID_MIN);
    localparam int PULSE_MAX_I = int'(PULSE_VALID_MAX);
    localparam int PULSE_TOP_I = (1 << PULSE_W) - 1;

    typedef struct packed {
        logic [PULSE_W-1:0] throttle;
        logic [PULSE_W-1:0] yaw;
        logic [PULSE_W-1:0] pitch;
        logic [PULSE_W-1:0] roll;
    } stick_frame_t;

    typedef struct packed {
        logic [1:0]         fill;
        logic               armed;
        logic [PULSE_W-1:0] throttle;
        logic [CMD_W-1:0]   yaw;
        logic [CMD_W-1:0]   pitch;
        logic [CMD_W-1:0]   roll;
    } stick_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [APB_W-1:0]    pwdata = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    // Predicted block state and register copies.
    logic [PULSE_W-1:0] cfg_center = CENTER_RESET;
    logic [PULSE_W-1:0] cfg_low    = LOW_THR_RESET;
    logic [PULSE_W-1:0] cfg_high   = HIGH_THR_RESET;
    logic [HOLD_W-1:0]  cfg_hold   = HOLD_RESET;
    logic [FLAG_W-1:0]  flags_q    = '0;
    logic [HOLD_W-1:0]  hold_q     = '0;
    logic               armed_q    = 1'b0;

    stick_frame_t  pending_frames[$];
    stick_result_t expected_results[$];
    stick_result_t mon_got;
    stick_result_t mon_want;

    logic frame_held = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;

    rc_stick_command_and_arming dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= 100) begin
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        end
    endtask

    function automatic logic [CMD_W-1:0] scale_stick(logic [PULSE_W-1:0] pulse,
                                                     logic negate);
        int diff;
        int q;
        diff = int'(pulse) - int'(cfg_center);
        // Integer division truncates toward zero, as the commands require.
        q = diff / 4;
        if (negate) begin
            q = -q;
        end
        return q[CMD_W-1:0];
    endfunction

    function automatic stick_result_t advance_stick_model(stick_frame_t frame);
        stick_result_t      res;
        logic [PULSE_W-1:0] pulse [NUM_CH];
        logic               checking;
        pulse[0] = frame.roll;
        pulse[1] = frame.pitch;
        pulse[2] = frame.yaw;
        pulse[3] = frame.throttle;
        res.fill     = '0;
        res.roll     = scale_stick(frame.roll, 1'b0);
        res.pitch    = scale_stick(frame.pitch, 1'b0);
        res.yaw      = scale_stick(frame.yaw, 1'b1);
        res.throttle = frame.throttle;

        // The first out-of-range channel ends the check for this frame.
        checking = 1'b1;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (pulse[ch] < PULSE_VALID_MIN || pulse[ch] > PULSE_VALID_MAX) begin
                checking = 1'b0;
            end
            if (checking) begin
                if (pulse[ch] < cfg_low) begin
                    flags_q[2*ch] = 1'b1;
                end else if (pulse[ch] > cfg_high) begin
                    flags_q[2*ch+1] = 1'b1;
                end
            end
        end

        if (flags_q != '0) begin
            if (hold_q < HOLD_SATURATE) begin
                hold_q = hold_q + 1'b1;
            end
        end else begin
            hold_q = '0;
        end

        if (hold_q == cfg_hold) begin
            if (armed_q) begin
                if ((flags_q & FLAG_YAW_LOW) != '0 && (flags_q & FLAG_THR_LOW) != '0) begin
                    armed_q = 1'b0;
                end
            end else begin
                if ((flags_q & FLAG_YAW_HIGH) != '0 && (flags_q & FLAG_THR_LOW) != '0) begin
                    armed_q = 1'b1;
                end
            end
            flags_q = '0;
            hold_q  = '0;
        end

        res.armed = armed_q;
        return res;
    endfunction

    function automatic logic [PULSE_W-1:0] pick_pulse(int lo, int hi);
        if (lo < 0) begin
            lo = 0;
        end
        if (hi > PULSE_TOP_I) begin
            hi = PULSE_TOP_I;
        end
        // An empty window (possible at extreme thresholds) falls back to any value.
        if (lo > hi) begin
            return PULSE_W'($urandom_range(PULSE_TOP_I, 0));
        end
        return PULSE_W'($urandom_range(hi, lo));
    endfunction

    // Input driver: presents queued frames and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            frame_held = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(advance_stick_model(s_tdata));
                frame_held = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_frames.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tdata <= pending_frames.pop_front();
                    s_tvalid <= 1'b1;
                    frame_held = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = m_tdata;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no frame pending", m_tdata[31:0], '0);
            end else begin
                mon_want = expected_results.pop_front();
                if (mon_got.roll != mon_want.roll)
                    report_mismatch("roll_command", 32'(mon_got.roll), 32'(mon_want.roll));
                if (mon_got.pitch != mon_want.pitch)
                    report_mismatch("pitch_command", 32'(mon_got.pitch), 32'(mon_want.pitch));
                if (mon_got.yaw != mon_want.yaw)
                    report_mismatch("yaw_command", 32'(mon_got.yaw), 32'(mon_want.yaw));
                if (mon_got.throttle != mon_want.throttle)
                    report_mismatch("throttle_command", 32'(mon_got.throttle),
                                    32'(mon_want.throttle));
                if (mon_got.armed != mon_want.armed)
                    report_mismatch("armed_flag", 32'(mon_got.armed), 32'(mon_want.armed));
                if (mon_got.fill != mon_want.fill)
                    report_mismatch("zero fill", 32'(mon_got.fill), 32'(mon_want.fill));
            end
        end
    end

    // Watchdog on cycles in which no transaction completes on any port.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("rc_stick_command_and_arming_tb NOT OK");
            $finish;
        end
    end

    task automatic apb_access(logic write, cfg_reg_t idx, logic [APB_W-1:0] wdata,
                              output logic [APB_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        logic [APB_W-1:0] rdata;
        apb_access(1'b1, idx, APB_W'(value), rdata);
        case (idx)
            REG_CENTER:   cfg_center = PULSE_W'(value);
            REG_LOW_THR:  cfg_low    = PULSE_W'(value);
            REG_HIGH_THR: cfg_high   = PULSE_W'(value);
            REG_HOLD:     cfg_hold   = HOLD_W'(value);
            default: ;
        endcase
        apb_access(1'b0, idx, '0, rdata);
        if (rdata != APB_W'(value)) begin
            report_mismatch("register read back", rdata, APB_W'(value));
        end
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || frame_held || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic queue_frame(int roll, int pitch, int yaw, int throttle, int repeats = 1);
        for (int i = 0; i < repeats; i++) begin
            pending_frames.push_back({PULSE_W'(throttle), PULSE_W'(yaw),
                                      PULSE_W'(pitch), PULSE_W'(roll)});
        end
    endtask

    task automatic queue_random_frames(int count);
        logic [PULSE_W-1:0] ch [NUM_CH];
        int left;
        int kind;
        int len;
        int victim;
        logic arming;
        int mid_lo;
        int mid_hi;
        int low_top;
        int high_bot;
        mid_lo   = (int'(cfg_low) > PULSE_MIN_I) ? int'(cfg_low) : PULSE_MIN_I;
        mid_hi   = (int'(cfg_high) < PULSE_MAX_I) ? int'(cfg_high) : PULSE_MAX_I;
        low_top  = (int'(cfg_low) - 1 < PULSE_MAX_I) ? int'(cfg_low) - 1 : PULSE_MAX_I;
        high_bot = (int'(cfg_high) + 1 > PULSE_MIN_I) ? int'(cfg_high) + 1 : PULSE_MIN_I;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(9, 0);
            len = 1;
            if (kind < 5) begin
                // Held gesture, a little shorter or longer than the hold count.
                arming = 1'($urandom_range(1, 0));
                len = int'(cfg_hold) + $urandom_range(4, 0) - 2;
                if (len < 1) begin
                    len = 1;
                end
            end
            for (int i = 0; i < len && left > 0; i++) begin
                if (kind < 5) begin
                    ch[0] = pick_pulse(mid_lo, mid_hi);
                    ch[1] = pick_pulse(mid_lo, mid_hi);
                    if ($urandom_range(11, 0) == 0) begin
                        ch[$urandom_range(1, 0)] = pick_pulse(PULSE_MIN_I, PULSE_MAX_I);
                    end
                    ch[2] = arming ? pick_pulse(high_bot, PULSE_MAX_I)
                                   : pick_pulse(PULSE_MIN_I, low_top);
                    ch[3] = pick_pulse(PULSE_MIN_I, low_top);
                    if ($urandom_range(24, 0) == 0) begin
                        victim = $urandom_range(NUM_CH - 1, 0);
                        ch[victim] = $urandom_range(1, 0) ?
                                     pick_pulse(0, PULSE_MIN_I - 1) :
                                     pick_pulse(PULSE_MAX_I + 1, PULSE_TOP_I);
                    end
                end else begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (kind < 7) begin
                            ch[c] = pick_pulse(mid_lo, mid_hi);
                        end else if (kind < 9) begin
                            ch[c] = pick_pulse(PULSE_MIN_I, PULSE_MAX_I);
                        end else begin
                            ch[c] = pick_pulse(0, PULSE_TOP_I);
                        end
                    end
                end
                pending_frames.push_back({ch[3], ch[2], ch[1], ch[0]});
                left--;
            end
        end
    endtask

    task automatic run_phase(int center, int low_thr, int high_thr, int hold,
                             int send_pct, int recv_pct, int count);
        write_reg(REG_CENTER, center);
        write_reg(REG_LOW_THR, low_thr);
        write_reg(REG_HIGH_THR, high_thr);
        write_reg(REG_HOLD, hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        // The sender holds off halfway until every result of the first half is back.
        queue_random_frames(count / 2);
        wait_drained();
        queue_random_frames(count - count / 2);
        wait_drained();
    endtask

    initial begin
        logic [APB_W-1:0] rdata;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        apb_access(1'b0, REG_CENTER, '0, rdata);
        if (rdata != APB_W'(CENTER_RESET))
            report_mismatch("reset center", rdata, APB_W'(CENTER_RESET));
        apb_access(1'b0, REG_LOW_THR, '0, rdata);
        if (rdata != APB_W'(LOW_THR_RESET))
            report_mismatch("reset low", rdata, APB_W'(LOW_THR_RESET));
        apb_access(1'b0, REG_HIGH_THR, '0, rdata);
        if (rdata != APB_W'(HIGH_THR_RESET))
            report_mismatch("reset high", rdata, APB_W'(HIGH_THR_RESET));
        apb_access(1'b0, REG_HOLD, '0, rdata);
        if (rdata != APB_W'(HOLD_RESET))
            report_mismatch("reset hold", rdata, APB_W'(HOLD_RESET));

        // Directed frames with a short hold so gestures complete quickly.
        write_reg(REG_HOLD, 3);
        queue_frame(0, 0, 0, 0);
        queue_frame(4095, 4095, 4095, 4095);
        queue_frame(900, 900, 900, 900);
        queue_frame(2000, 2000, 2000, 2000);
        queue_frame(1500, 2001, 1000, 1000);
        queue_frame(1500, 1500, 899, 1000);
        queue_frame(1500, 1500, 1500, 1500);
        queue_frame(1497, 1503, 1496, 1234);
        queue_frame(1500, 1500, 1950, 1000, 3);
        queue_frame(1500, 1500, 1500, 1500);
        queue_frame(1500, 1500, 1000, 1000, 3);
        queue_frame(1500, 1500, 1950, 1000, 3);
        queue_frame(1500, 1500, 1000, 1000, 2);
        queue_frame(1500, 1500, 1500, 1500);
        queue_frame(1500, 1500, 1000, 1000, 3);
        queue_frame(1100, 1900, 1099, 1901);
        queue_frame('hAAA, 'h555, 'hAAA, 'h555);
        queue_frame('h555, 'hAAA, 'h555, 'hAAA);
        wait_drained();

        run_phase(1500, 1100, 1900, 5, 0, 0, 300);
        run_phase(1500, 1100, 1900, 1, 55, 0, 250);
        run_phase(1520, 1050, 1950, 8, 0, 55, 250);
        run_phase(0, 0, 4095, 0, 29, 29, 150);
        run_phase(4095, 4095, 0, 255, 0, 0, 150);
        run_phase(1500, 1100, 1900, 250, 29, 29, 600);
        run_phase(1480, 1200, 1800, 100, 0, 0, 200);

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("rc_stick_command_and_arming_tb OK");
        end else begin
            $display("rc_stick_command_and_arming_tb NOT OK");
        end
        $finish;
    end

endmodule
